// ===== rtl/nmea_gga_pkg.sv =====
package nmea_gga_pkg;

  localparam int MINUTE_FRAC_DIGITS_DEF = 5;
  localparam logic [4:0] MIN_FIELDS = 5'd15;

  localparam logic [7:0] HEADER_TEXT [6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_SOUTH = 8'h53;
  localparam logic [7:0] CH_WEST  = 8'h57;

  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_QUAL = 4'd6;
  localparam logic [3:0] FLD_SATS = 4'd7;
  localparam logic [3:0] FLD_HDOP = 4'd8;
  localparam logic [3:0] FLD_ALT  = 4'd9;
  localparam logic [3:0] FLD_SEP  = 4'd11;
  localparam logic [3:0] FLD_AGE  = 4'd13;
  localparam logic [3:0] FLD_STN  = 4'd14;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_HEADER,
    ERR_CHECKSUM,
    ERR_FIELDS,
    ERR_NUMBER
  } err_t;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < n; i++) r = r * 32'd10;
    return r;
  endfunction

endpackage

// ===== rtl/nmea_gga_sentence_parser.sv =====
// channel | signals                                   | direction
// input   | in_valid, in_stall, char_byte,            | one character per request
//         | end_of_sentence                           |
// output  | out_valid, out_stall, error_code ...      | one result per sentence
//         | diff_station_id                           |
// One character is taken every cycle while in_stall is low; the conversion pipe is three
// registers deep (p1, p2, p3) plus the result register, which a result passes in that order.
// Reset clears the parser, the decoded fields (hdop to 99.9), the pipe valids and out_valid.
// in_stall rises only while a finished result is in the last pipe stage and the
// result register holds an untaken result under out_stall.
module nmea_gga_sentence_parser #(
  parameter int MINUTE_FRAC_DIGITS = nmea_gga_pkg::MINUTE_FRAC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_byte,
  input  logic               end_of_sentence,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         error_code,
  output logic [23:0]        utc_hundredths,
  output logic signed [30:0] latitude_e7,
  output logic signed [31:0] longitude_e7,
  output logic [3:0]         fix_quality,
  output logic [6:0]         satellite_count,
  output logic [13:0]        hdop_tenths,
  output logic signed [20:0] altitude_dm,
  output logic signed [17:0] geoid_sep_dm,
  output logic [13:0]        diff_age_tenths,
  output logic [9:0]         diff_station_id
);

  localparam int FK  = (MINUTE_FRAC_DIGITS > 2) ? MINUTE_FRAC_DIGITS : 2;
  localparam int FCW = $clog2(FK + 1);
  localparam logic [28:0] RECIP15 = 29'd286331154;

  typedef enum logic [2:0] {PH_HEADER, PH_BODY, PH_CK1, PH_CK2, PH_TAIL} phase_t;

  typedef struct packed {
    logic                 valid;
    logic                 fin;
    nmea_gga_pkg::err_t   err;
    logic [1:0]           hemi;
    logic                 emit;
    logic [3:0]           idx;
    logic                 neg;
    logic                 big;
    logic [5:0][3:0]      ipd;
    logic [FK-1:0][3:0]   fd;
  } p1_t;

  typedef struct packed {
    logic                 valid;
    logic                 fin;
    nmea_gga_pkg::err_t   err;
    logic [1:0]           hemi;
    logic                 emit;
    logic [3:0]           idx;
    logic                 neg;
    logic [31:0]          val;
    logic [7:0]           deg;
    logic [27:0]          z;
  } p2_t;

  typedef struct packed {
    logic                 valid;
    logic                 fin;
    nmea_gga_pkg::err_t   err;
    logic [1:0]           hemi;
    logic                 emit;
    logic [3:0]           idx;
    logic                 neg;
    logic [31:0]          val;
    logic [30:0]          deg_e7;
    logic [24:0]          q;
  } p3_t;

  // parser state
  phase_t             ph, ph_next;
  logic [2:0]         hdr_pos, hdr_pos_next;
  logic               hdr_err, hdr_err_next;
  logic               csum_err, csum_err_next;
  logic               num_err, num_err_next;
  logic [4:0]         fld, fld_next;
  logic [1:0]         cif, cif_next;
  logic [7:0]         xr, xr_next;
  logic [7:0]         rx, rx_next;
  logic               neg, neg_next;
  logic               dig, dig_next;
  logic               dot, dot_next;
  logic               bad, bad_next;
  logic               first_s, first_s_next;
  logic               first_w, first_w_next;
  logic [5:0][3:0]    ipd, ipd_next;
  logic               big, big_next;
  logic [FK-1:0][3:0] fd, fd_next;
  logic [FCW-1:0]     fcnt, fcnt_next;
  logic [1:0]         hemi, hemi_next;

  logic               accept, adv, emit, do_close;
  logic [3:0]         cidx;
  logic [3:0]         dval;
  logic [4:0]         hexv;
  nmea_gga_pkg::err_t err_now;

  p1_t p1, p1_next;
  p2_t p2, p2_next;
  p3_t p3, p3_next;

  // decoded fields
  logic [23:0] dec_time;
  logic [30:0] dec_lat;
  logic [31:0] dec_lon;
  logic [3:0]  dec_qual;
  logic [6:0]  dec_sats;
  logic [13:0] dec_hdop;
  logic [20:0] dec_alt;
  logic [17:0] dec_sep;
  logic [13:0] dec_age;
  logic [9:0]  dec_stn;

  logic [31:0] mag;
  logic [30:0] lat_v;
  logic [31:0] lon_v;

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= nmea_gga_pkg::CH_ZERO && c <= nmea_gga_pkg::CH_NINE) begin
      r = {1'b1, 4'(c - nmea_gga_pkg::CH_ZERO)};
    end else if (c >= nmea_gga_pkg::CH_UP_A && c <= nmea_gga_pkg::CH_UP_F) begin
      r = {1'b1, 4'(c - nmea_gga_pkg::CH_UP_A + 8'd10)};
    end else if (c >= nmea_gga_pkg::CH_LO_A && c <= nmea_gga_pkg::CH_LO_F) begin
      r = {1'b1, 4'(c - nmea_gga_pkg::CH_LO_A + 8'd10)};
    end
    return r;
  endfunction

  assign adv      = !(p3.valid && p3.fin && out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign dval     = 4'(char_byte - nmea_gga_pkg::CH_ZERO);
  assign hexv     = hex_dec(char_byte);
  assign cidx     = fld[3:0];

  // parser
  always_comb begin
    ph_next       = ph;
    hdr_pos_next  = hdr_pos;
    hdr_err_next  = hdr_err;
    csum_err_next = csum_err;
    num_err_next  = num_err;
    fld_next      = fld;
    cif_next      = cif;
    xr_next       = xr;
    rx_next       = rx;
    neg_next      = neg;
    dig_next      = dig;
    dot_next      = dot;
    bad_next      = bad;
    first_s_next  = first_s;
    first_w_next  = first_w;
    ipd_next      = ipd;
    big_next      = big;
    fd_next       = fd;
    fcnt_next     = fcnt;
    hemi_next     = hemi;
    do_close      = 1'b0;
    emit          = 1'b0;
    err_now       = nmea_gga_pkg::ERR_NONE;
    p1_next       = p1;
    p1_next.valid = 1'b0;

    if (accept) begin
      unique case (ph)
        PH_HEADER: begin
          if (char_byte != nmea_gga_pkg::HEADER_TEXT[hdr_pos]) hdr_err_next = 1'b1;
          if (hdr_pos != 3'd0) xr_next = xr ^ char_byte;
          hdr_pos_next = hdr_pos + 3'd1;
          if (hdr_pos == 3'd5) ph_next = PH_BODY;
        end
        PH_BODY: begin
          if (char_byte == nmea_gga_pkg::CH_STAR) begin
            do_close = fld < nmea_gga_pkg::MIN_FIELDS;
            ph_next  = PH_CK1;
          end else begin
            xr_next = xr ^ char_byte;
            if (char_byte == nmea_gga_pkg::CH_COMMA) begin
              do_close = fld < nmea_gga_pkg::MIN_FIELDS;
              if (fld != 5'd31) fld_next = fld + 5'd1;
              cif_next     = 2'd0;
              neg_next     = 1'b0;
              dig_next     = 1'b0;
              dot_next     = 1'b0;
              bad_next     = 1'b0;
              first_s_next = 1'b0;
              first_w_next = 1'b0;
              ipd_next     = '0;
              big_next     = 1'b0;
              fd_next      = '0;
              fcnt_next    = '0;
            end else if (fld != 5'd0) begin
              if (cif == 2'd0) begin
                first_s_next = char_byte == nmea_gga_pkg::CH_SOUTH;
                first_w_next = char_byte == nmea_gga_pkg::CH_WEST;
              end
              if (cif == 2'd0 && (char_byte == nmea_gga_pkg::CH_PLUS ||
                                  char_byte == nmea_gga_pkg::CH_MINUS)) begin
                if (char_byte == nmea_gga_pkg::CH_MINUS) neg_next = 1'b1;
              end else if (char_byte >= nmea_gga_pkg::CH_ZERO &&
                           char_byte <= nmea_gga_pkg::CH_NINE) begin
                dig_next = 1'b1;
                if (dot) begin
                  if (fcnt < FCW'(FK)) begin
                    for (int i = 0; i < FK; i++) begin
                      if (fcnt == FCW'(i)) fd_next[i] = dval;
                    end
                    fcnt_next = fcnt + 1'b1;
                  end
                end else begin
                  if (ipd[5] != 4'd0) big_next = 1'b1;
                  ipd_next = {ipd[4:0], dval};
                end
              end else if (char_byte == nmea_gga_pkg::CH_DOT && !dot) begin
                dot_next = 1'b1;
              end else begin
                bad_next = 1'b1;
              end
              if (cif != 2'd2) cif_next = cif + 2'd1;
            end
          end
        end
        PH_CK1, PH_CK2: begin
          if (!hexv[4]) csum_err_next = 1'b1;
          else rx_next = {rx[3:0], hexv[3:0]};
          ph_next = (ph == PH_CK1) ? PH_CK2 : PH_TAIL;
        end
        PH_TAIL: begin
        end
        default: begin
        end
      endcase

      if (do_close) begin
        if (cidx == nmea_gga_pkg::FLD_NS && cif == 2'd1 && first_s) hemi_next[0] = 1'b1;
        if (cidx == nmea_gga_pkg::FLD_EW && cif == 2'd1 && first_w) hemi_next[1] = 1'b1;
        case (cidx)
          nmea_gga_pkg::FLD_TIME, nmea_gga_pkg::FLD_LAT, nmea_gga_pkg::FLD_LON,
          nmea_gga_pkg::FLD_QUAL, nmea_gga_pkg::FLD_SATS, nmea_gga_pkg::FLD_HDOP,
          nmea_gga_pkg::FLD_ALT, nmea_gga_pkg::FLD_SEP, nmea_gga_pkg::FLD_AGE,
          nmea_gga_pkg::FLD_STN: begin
            if (cif == 2'd0) begin
              if (cidx == nmea_gga_pkg::FLD_LAT || cidx == nmea_gga_pkg::FLD_LON)
                num_err_next = 1'b1;
            end else if (bad || !dig) begin
              num_err_next = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (ph_next == PH_HEADER || hdr_err_next) err_now = nmea_gga_pkg::ERR_HEADER;
      else if (ph_next != PH_TAIL || csum_err_next || rx_next != xr_next)
        err_now = nmea_gga_pkg::ERR_CHECKSUM;
      else if (fld_next < nmea_gga_pkg::MIN_FIELDS - 5'd1) err_now = nmea_gga_pkg::ERR_FIELDS;
      else if (num_err_next) err_now = nmea_gga_pkg::ERR_NUMBER;

      p1_next.valid = emit || end_of_sentence;
      p1_next.fin   = end_of_sentence;
      p1_next.err   = err_now;
      p1_next.hemi  = hemi_next;
      p1_next.emit  = emit;
      p1_next.idx   = cidx;
      p1_next.neg   = neg;
      p1_next.big   = big;
      p1_next.ipd   = ipd;
      p1_next.fd    = fd;

      if (end_of_sentence) begin
        ph_next       = PH_HEADER;
        hdr_pos_next  = 3'd0;
        hdr_err_next  = 1'b0;
        csum_err_next = 1'b0;
        num_err_next  = 1'b0;
        fld_next      = 5'd0;
        cif_next      = 2'd0;
        xr_next       = 8'd0;
        rx_next       = 8'd0;
        neg_next      = 1'b0;
        dig_next      = 1'b0;
        dot_next      = 1'b0;
        bad_next      = 1'b0;
        first_s_next  = 1'b0;
        first_w_next  = 1'b0;
        ipd_next      = '0;
        big_next      = 1'b0;
        fd_next       = '0;
        fcnt_next     = '0;
        hemi_next     = 2'd0;
      end
    end
  end

  // stage 2: digit conversion and saturation
  logic [20:0] ipv;
  logic [24:0] tm;
  logic [26:0] traw;
  logic [13:0] dv;
  logic [29:0] xsum;
  logic [29:0] ysum;

  always_comb begin
    ipv = p1.big ? 21'd1000000 :
          21'(p1.ipd[0]) + 21'(p1.ipd[1]) * 21'd10 + 21'(p1.ipd[2]) * 21'd100 +
          21'(p1.ipd[3]) * 21'd1000 + 21'(p1.ipd[4]) * 21'd10000 +
          21'(p1.ipd[5]) * 21'd100000;
    tm = 25'(ipv) * 25'd10 + 25'(p1.fd[0]);
    traw = (27'(p1.ipd[5]) * 27'd10 + 27'(p1.ipd[4])) * 27'd360000 +
           (27'(p1.ipd[3]) * 27'd10 + 27'(p1.ipd[2])) * 27'd6000 +
           (27'(p1.ipd[1]) * 27'd10 + 27'(p1.ipd[0])) * 27'd100 +
           27'(p1.fd[0]) * 27'd10 + 27'(p1.fd[1]);
    dv = 14'(p1.ipd[5]) * 14'd1000 + 14'(p1.ipd[4]) * 14'd100 +
         14'(p1.ipd[3]) * 14'd10 + 14'(p1.ipd[2]);
    xsum = (30'(p1.ipd[1]) * 30'd10 + 30'(p1.ipd[0])) * 30'd10000000;
    for (int i = 0; i < MINUTE_FRAC_DIGITS; i++) begin
      xsum = xsum + 30'(p1.fd[i]) * 30'(nmea_gga_pkg::pow10(6 - i));
    end
    ysum = xsum + 30'd30;

    p2_next       = '0;
    p2_next.valid = p1.valid;
    p2_next.fin   = p1.fin;
    p2_next.err   = p1.err;
    p2_next.hemi  = p1.hemi;
    p2_next.emit  = p1.emit;
    p2_next.idx   = p1.idx;
    p2_next.neg   = p1.neg;
    p2_next.deg   = (p1.big || dv > 14'd180) ? 8'd180 : dv[7:0];
    p2_next.z     = ysum[29:2];
    case (p1.idx)
      nmea_gga_pkg::FLD_TIME:
        p2_next.val = p1.neg ? 32'd0 :
                      (p1.big || traw > 27'd8639999) ? 32'd8639999 : 32'(traw);
      nmea_gga_pkg::FLD_QUAL:
        p2_next.val = p1.neg ? 32'd0 : (ipv > 21'd15) ? 32'd15 : 32'(ipv);
      nmea_gga_pkg::FLD_SATS:
        p2_next.val = p1.neg ? 32'd0 : (ipv > 21'd99) ? 32'd99 : 32'(ipv);
      nmea_gga_pkg::FLD_STN:
        p2_next.val = p1.neg ? 32'd0 : (ipv > 21'd1023) ? 32'd1023 : 32'(ipv);
      nmea_gga_pkg::FLD_HDOP, nmea_gga_pkg::FLD_AGE:
        p2_next.val = p1.neg ? 32'd0 : (tm > 25'd9999) ? 32'd9999 : 32'(tm);
      nmea_gga_pkg::FLD_ALT:
        p2_next.val = p1.neg ? 32'd0 - ((tm > 25'd99999) ? 32'd99999 : 32'(tm)) :
                      (tm > 25'd999999) ? 32'd999999 : 32'(tm);
      nmea_gga_pkg::FLD_SEP:
        p2_next.val = p1.neg ? 32'd0 - ((tm > 25'd99999) ? 32'd99999 : 32'(tm)) :
                      (tm > 25'd99999) ? 32'd99999 : 32'(tm);
      default: p2_next.val = 32'd0;
    endcase
  end

  // stage 3: minutes divided by 60 through a reciprocal, degrees scaled
  logic [56:0] prod;

  always_comb begin
    prod          = 57'(p2.z) * 57'(RECIP15);
    p3_next.valid = p2.valid;
    p3_next.fin   = p2.fin;
    p3_next.err   = p2.err;
    p3_next.hemi  = p2.hemi;
    p3_next.emit  = p2.emit;
    p3_next.idx   = p2.idx;
    p3_next.neg   = p2.neg;
    p3_next.val   = p2.val;
    p3_next.deg_e7 = 31'(p2.deg) * 31'd10000000;
    p3_next.q     = prod[56:32];
  end

  always_comb begin
    mag = 32'(p3.deg_e7) + 32'(p3.q);
    if (p3.idx == nmea_gga_pkg::FLD_LAT) begin
      if (mag > 32'd900000000) mag = 32'd900000000;
    end else if (mag > 32'd1800000000) begin
      mag = 32'd1800000000;
    end
    lat_v = p3.neg ? 31'd0 - mag[30:0] : mag[30:0];
    lon_v = p3.neg ? 32'd0 - mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= PH_HEADER;
      hdr_pos   <= 3'd0;
      hdr_err   <= 1'b0;
      csum_err  <= 1'b0;
      num_err   <= 1'b0;
      fld       <= 5'd0;
      cif       <= 2'd0;
      xr        <= 8'd0;
      rx        <= 8'd0;
      neg       <= 1'b0;
      dig       <= 1'b0;
      dot       <= 1'b0;
      bad       <= 1'b0;
      first_s   <= 1'b0;
      first_w   <= 1'b0;
      ipd       <= '0;
      big       <= 1'b0;
      fd        <= '0;
      fcnt      <= '0;
      hemi      <= 2'd0;
      p1        <= '0;
      p2        <= '0;
      p3        <= '0;
      out_valid <= 1'b0;
      dec_time  <= '0;
      dec_lat   <= '0;
      dec_lon   <= '0;
      dec_qual  <= '0;
      dec_sats  <= '0;
      dec_hdop  <= 14'd999;
      dec_alt   <= '0;
      dec_sep   <= '0;
      dec_age   <= '0;
      dec_stn   <= '0;
    end else begin
      ph       <= ph_next;
      hdr_pos  <= hdr_pos_next;
      hdr_err  <= hdr_err_next;
      csum_err <= csum_err_next;
      num_err  <= num_err_next;
      fld      <= fld_next;
      cif      <= cif_next;
      xr       <= xr_next;
      rx       <= rx_next;
      neg      <= neg_next;
      dig      <= dig_next;
      dot      <= dot_next;
      bad      <= bad_next;
      first_s  <= first_s_next;
      first_w  <= first_w_next;
      ipd      <= ipd_next;
      big      <= big_next;
      fd       <= fd_next;
      fcnt     <= fcnt_next;
      hemi     <= hemi_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (adv) begin
        p1 <= p1_next;
        p2 <= p2_next;
        p3 <= p3_next;
        if (p3.valid && p3.emit) begin
          case (p3.idx)
            nmea_gga_pkg::FLD_TIME: dec_time <= p3.val[23:0];
            nmea_gga_pkg::FLD_LAT:  dec_lat  <= lat_v;
            nmea_gga_pkg::FLD_LON:  dec_lon  <= lon_v;
            nmea_gga_pkg::FLD_QUAL: dec_qual <= p3.val[3:0];
            nmea_gga_pkg::FLD_SATS: dec_sats <= p3.val[6:0];
            nmea_gga_pkg::FLD_HDOP: dec_hdop <= p3.val[13:0];
            nmea_gga_pkg::FLD_ALT:  dec_alt  <= p3.val[20:0];
            nmea_gga_pkg::FLD_SEP:  dec_sep  <= p3.val[17:0];
            nmea_gga_pkg::FLD_AGE:  dec_age  <= p3.val[13:0];
            nmea_gga_pkg::FLD_STN:  dec_stn  <= p3.val[9:0];
            default: begin
            end
          endcase
        end
        if (p3.valid && p3.fin) begin
          out_valid  <= 1'b1;
          error_code <= p3.err;
          if (p3.err == nmea_gga_pkg::ERR_NONE) begin
            utc_hundredths  <= dec_time;
            latitude_e7     <= p3.hemi[0] ? 31'd0 - dec_lat : dec_lat;
            longitude_e7    <= p3.hemi[1] ? 32'd0 - dec_lon : dec_lon;
            fix_quality     <= dec_qual;
            satellite_count <= dec_sats;
            hdop_tenths     <= dec_hdop;
            altitude_dm     <= dec_alt;
            geoid_sep_dm    <= dec_sep;
            diff_age_tenths <= dec_age;
            diff_station_id <= dec_stn;
          end else begin
            utc_hundredths  <= '0;
            latitude_e7     <= '0;
            longitude_e7    <= '0;
            fix_quality     <= '0;
            satellite_count <= '0;
            hdop_tenths     <= '0;
            altitude_dm     <= '0;
            geoid_sep_dm    <= '0;
            diff_age_tenths <= '0;
            diff_station_id <= '0;
          end
          dec_time <= '0;
          dec_lat  <= '0;
          dec_lon  <= '0;
          dec_qual <= '0;
          dec_sats <= '0;
          dec_hdop <= 14'd999;
          dec_alt  <= '0;
          dec_sep  <= '0;
          dec_age  <= '0;
          dec_stn  <= '0;
        end
      end
    end
  end

endmodule
